// File: src/swap_readahead_window_assert.svh
// assertion macros shared by the swap readahead window checker
// depends on a clk and an active-low rst_n in the scope of use
`ifndef SWAP_READAHEAD_WINDOW_ASSERT_SVH
`define SWAP_READAHEAD_WINDOW_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define SWRA_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define SWRA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/swra_pkg.sv
// shared types and constants for the swap readahead window block
// no dependencies
package swra_pkg;

    localparam int OFFSET_BITS    = 32;
    localparam int HIT_BITS       = 8;
    localparam int WIN_BITS       = 11;
    localparam int ORDER_BITS     = 4;
    localparam int RND_BITS       = HIT_BITS + 2;
    localparam int CMP_BITS       = (RND_BITS > WIN_BITS) ? RND_BITS : WIN_BITS;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = OFFSET_BITS;

    localparam logic [ORDER_BITS-1:0]  ORDER_CAP        = 4'd10;
    localparam logic [ORDER_BITS-1:0]  ORDER_RESET      = 4'd3;
    localparam logic [OFFSET_BITS-1:0] SLOT_TOTAL_RESET = {OFFSET_BITS{1'b1}};
    localparam logic [HIT_BITS-1:0]    HIT_RESET        = HIT_BITS'(4);
    localparam logic [HIT_BITS-1:0]    HIT_MAX          = {HIT_BITS{1'b1}};

    // event kinds
    localparam logic KIND_HIT   = 1'b0;
    localparam logic KIND_FAULT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLUSTER_ORDER = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOT_TOTAL    = 1'd1;

    typedef struct packed {
        logic                   kind;
        logic [OFFSET_BITS-1:0] fault_offset;
        logic                   device_congested;
    } event_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] first_slot;
        logic [OFFSET_BITS-1:0] last_slot;
        logic [WIN_BITS-1:0]    window_pages;
        logic                   synchronous;
    } window_t;

    typedef struct packed {
        logic [ORDER_BITS-1:0]  cluster_order;
        logic [OFFSET_BITS-1:0] slot_total;
    } cfg_t;

    typedef struct packed {
        logic [HIT_BITS-1:0]    hit_count;
        logic [OFFSET_BITS-1:0] prev_fault_slot;
        logic [WIN_BITS-1:0]    last_window;
    } state_t;

endpackage

// File: src/swap_readahead_window.sv
// Swap readahead window predictor. Events enter through a one-entry input
// stage, and a new event is taken every cycle unless a fault event waits
// there for a stalled consumer; a fault event's window is computed from the
// stage in one pass and registered in the result register. Hit events use
// the same stage, bump the hit counter and give no result. A result held by a
// stalled consumer blocks a fault event only once it reaches the input stage.
// Writes to cluster_order and slot_total take effect at the next clock edge.
// depends on swra_pkg, swra_cfg_regs and swra_window_calc
module swap_readahead_window (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                event_valid,
    output logic                                event_ready,
    input  swra_pkg::event_t                    event_data,
    output logic                                window_valid,
    input  logic                                window_ready,
    output swra_pkg::window_t                   window_data,
    input  logic                                cfg_write_en,
    input  logic [swra_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [swra_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    swra_pkg::cfg_t    cfg;
    swra_pkg::state_t  state_reg;
    swra_pkg::state_t  state_next;
    swra_pkg::state_t  calc_state;
    swra_pkg::window_t calc_result;
    swra_pkg::event_t  stage_item_reg;
    swra_pkg::window_t out_item_reg;
    logic              stage_valid_reg;
    logic              stage_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              stage_fire;
    logic              stage_is_fault;
    logic              event_fire;

    swra_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (cfg_write_en),
        .index    (cfg_index),
        .data     (cfg_data),
        .cfg      (cfg)
    );

    swra_window_calc u_window_calc (
        .item       (stage_item_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .result     (calc_result),
        .state_next (calc_state)
    );

    always_comb
    begin
        out_free       = !out_valid_reg || window_ready;
        stage_is_fault = (stage_item_reg.kind == swra_pkg::KIND_FAULT);
        // hit events drain without needing the result register
        stage_fire     = stage_valid_reg && (!stage_is_fault || out_free);
        event_ready    = !stage_valid_reg || stage_fire;
        event_fire     = event_valid && event_ready;

        stage_valid_next = stage_valid_reg;
        if (event_fire)
            stage_valid_next = 1'b1;
        else if (stage_fire)
            stage_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (stage_fire && stage_is_fault)
            out_valid_next = 1'b1;
        else if (window_ready)
            out_valid_next = 1'b0;

        state_next = stage_fire ? calc_state : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg           <= 1'b0;
            out_valid_reg             <= 1'b0;
            state_reg.hit_count       <= swra_pkg::HIT_RESET;
            state_reg.prev_fault_slot <= '0;
            state_reg.last_window     <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            state_reg       <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (event_fire)
            stage_item_reg <= event_data;
        if (stage_fire && stage_is_fault)
            out_item_reg <= calc_result;
    end

    assign window_valid = out_valid_reg;
    assign window_data  = out_item_reg;

endmodule

// File: src/swra_cfg_regs.sv
// configuration registers of the swap readahead window block
// depends on swra_pkg
module swra_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_en,
    input  logic [swra_pkg::CFG_INDEX_BITS-1:0] index,
    input  logic [swra_pkg::CFG_DATA_BITS-1:0]  data,
    output swra_pkg::cfg_t                      cfg
);

    swra_pkg::cfg_t cfg_reg;
    swra_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (index)
                swra_pkg::CFG_CLUSTER_ORDER:
                begin
                    cfg_next.cluster_order = data[swra_pkg::ORDER_BITS-1:0];
                end
                swra_pkg::CFG_SLOT_TOTAL:
                begin
                    cfg_next.slot_total = data[swra_pkg::OFFSET_BITS-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cluster_order <= swra_pkg::ORDER_RESET;
            cfg_reg.slot_total    <= swra_pkg::SLOT_TOTAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/swra_window_calc.sv
// window size, alignment and clamp logic plus the next predictor state
// depends on swra_pkg
module swra_window_calc (
    input  swra_pkg::event_t  item,
    input  swra_pkg::cfg_t    cfg,
    input  swra_pkg::state_t  state,
    output swra_pkg::window_t result,
    output swra_pkg::state_t  state_next
);

    logic [swra_pkg::ORDER_BITS-1:0]  order_eff;
    logic [swra_pkg::WIN_BITS-1:0]    cap_pages;
    logic                             hits_zero;
    logic [swra_pkg::OFFSET_BITS-1:0] prev_up;
    logic [swra_pkg::OFFSET_BITS-1:0] prev_down;
    logic                             adjacent;
    logic [swra_pkg::RND_BITS-1:0]    smear;
    logic [swra_pkg::RND_BITS-1:0]    rounded;
    logic [swra_pkg::CMP_BITS-1:0]    raw_pages;
    logic [swra_pkg::CMP_BITS-1:0]    capped;
    logic [swra_pkg::CMP_BITS-1:0]    hold;
    logic [swra_pkg::CMP_BITS-1:0]    sized;
    logic [swra_pkg::WIN_BITS-1:0]    pages;
    logic [swra_pkg::WIN_BITS-1:0]    mask;
    logic [swra_pkg::OFFSET_BITS-1:0] mask_wide;
    logic [swra_pkg::OFFSET_BITS-1:0] first;
    logic [swra_pkg::OFFSET_BITS-1:0] last;

    always_comb
    begin
        order_eff = (cfg.cluster_order > swra_pkg::ORDER_CAP) ? swra_pkg::ORDER_CAP
                                                              : cfg.cluster_order;
        cap_pages = swra_pkg::WIN_BITS'(1) << order_eff;
        hits_zero = (state.hit_count == '0);
        prev_up   = state.prev_fault_slot + swra_pkg::OFFSET_BITS'(1);
        prev_down = state.prev_fault_slot - swra_pkg::OFFSET_BITS'(1);
        adjacent  = (item.fault_offset == prev_up) || (item.fault_offset == prev_down);

        // next power of two of hits + 2; hits >= 1 keeps this at 4 or more
        smear = swra_pkg::RND_BITS'(state.hit_count) + swra_pkg::RND_BITS'(1);
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
        rounded = smear + swra_pkg::RND_BITS'(1);

        if (hits_zero)
            raw_pages = adjacent ? swra_pkg::CMP_BITS'(2) : swra_pkg::CMP_BITS'(1);
        else
            raw_pages = swra_pkg::CMP_BITS'(rounded);

        capped = (raw_pages > swra_pkg::CMP_BITS'(cap_pages)) ? swra_pkg::CMP_BITS'(cap_pages)
                                                              : raw_pages;
        hold   = swra_pkg::CMP_BITS'(state.last_window >> 1);
        sized  = (capped < hold) ? hold : capped;
        pages  = swra_pkg::WIN_BITS'(sized);

        mask      = pages - swra_pkg::WIN_BITS'(1);
        mask_wide = swra_pkg::OFFSET_BITS'(mask);
        first     = item.fault_offset & ~mask_wide;
        last      = item.fault_offset | mask_wide;
        if (first == '0)
            first = swra_pkg::OFFSET_BITS'(1);
        if ((cfg.slot_total != '0) && (last >= cfg.slot_total))
            last = cfg.slot_total - swra_pkg::OFFSET_BITS'(1);

        result.first_slot   = item.fault_offset;
        result.last_slot    = item.fault_offset;
        result.window_pages = swra_pkg::WIN_BITS'(1);
        result.synchronous  = 1'b1;
        state_next          = state;

        if (item.kind == swra_pkg::KIND_HIT)
        begin
            if (state.hit_count != swra_pkg::HIT_MAX)
                state_next.hit_count = state.hit_count + swra_pkg::HIT_BITS'(1);
        end
        else if (order_eff != '0)
        begin
            state_next.hit_count   = '0;
            state_next.last_window = pages;
            if (hits_zero)
                state_next.prev_fault_slot = item.fault_offset;
            result.window_pages = pages;
            if ((mask != '0) && !item.device_congested)
            begin
                result.first_slot  = first;
                result.last_slot   = last;
                result.synchronous = 1'b0;
            end
        end
    end

endmodule

// File: src/swra_checker.sv
// port-level checks on the result channel of swap_readahead_window
// depends on swra_pkg and swap_readahead_window_assert.svh; bound to the top level
`include "swap_readahead_window_assert.svh"

module swra_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              window_valid,
    input logic              window_ready,
    input swra_pkg::window_t window_data
);

    // a stalled transaction keeps its payload
    `SWRA_ASSERT_NEXT(a_hold_stalled, window_valid && !window_ready, window_valid && $stable(window_data), "result changed while stalled")

    // every window size is a power of two no larger than 1024
    `SWRA_ASSERT_IMPLIES(a_pages_pow2, window_valid, $onehot(window_data.window_pages), "window size not a power of two")

    // a synchronous read covers only the faulting slot
    `SWRA_ASSERT_IMPLIES(a_sync_single, window_valid && window_data.synchronous, window_data.first_slot == window_data.last_slot, "synchronous read spans slots")

    // readahead never starts at slot zero and needs a window above one slot
    `SWRA_ASSERT_IMPLIES(a_ra_window, window_valid && !window_data.synchronous, (window_data.first_slot != '0) && (window_data.window_pages != 11'd1), "bad readahead window")

endmodule

bind swap_readahead_window swra_checker u_swra_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .window_valid (window_valid),
    .window_ready (window_ready),
    .window_data  (window_data)
);
